// ===== hdl/tlnu_pkg.sv =====
// Shared types and constants for the trigger table nibble unpacker.
package tlnu_pkg;

  localparam int unsigned NumStrips  = 16;
  localparam int unsigned RespW      = 4;
  localparam int unsigned BytePairs  = NumStrips / 2;
  localparam int unsigned StoreDepth = BytePairs - 1;
  localparam int unsigned PairIdxW   = $clog2(BytePairs);

  localparam logic [1:0] RespMinus = 2'd1;
  localparam logic [1:0] RespPlus  = 2'd2;
  localparam logic [1:0] RespUndef = 2'd3;

  localparam logic [4:0] DevInf = 5'd15;

  localparam logic [0:0] AddrBoardId = 1'b0;

  typedef logic [RespW-1:0] resp_t;

  typedef struct packed {
    logic low_minus;
    logic low_undef;
    logic low_plus;
    logic high_minus;
    logic high_undef;
    logic high_plus;
  } lane_flags_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] board;
    logic [4:0] strip_x;
    logic [4:0] deviation;
  } close_t;

endpackage

// ===== hdl/tlnu_lane.sv =====
// One strip lane: classifies a 4-bit response into its low and high pt flags.
module tlnu_lane (
  input  tlnu_pkg::resp_t       resp,
  output tlnu_pkg::lane_flags_t flags
);

  logic [1:0] lpt;
  logic [1:0] hpt;

  assign lpt = resp[1:0];
  assign hpt = resp[3:2];

  assign flags.low_minus  = (lpt == tlnu_pkg::RespMinus);
  assign flags.low_undef  = (lpt == tlnu_pkg::RespUndef);
  assign flags.low_plus   = (lpt == tlnu_pkg::RespPlus);
  assign flags.high_minus = (hpt == tlnu_pkg::RespMinus);
  assign flags.high_undef = (hpt == tlnu_pkg::RespUndef);
  assign flags.high_plus  = (hpt == tlnu_pkg::RespPlus);

endmodule

// ===== hdl/tlnu_collect.sv =====
// Address counter, strip response store and group close decision.
module tlnu_collect (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      accept,
  input  logic [7:0]                                lut_byte,
  input  logic [7:0]                                board_id,
  output logic                                      last_pair,
  output tlnu_pkg::close_t                          close_info,
  output tlnu_pkg::resp_t [tlnu_pkg::NumStrips-1:0] resps
);

  logic [13:0]                   byte_addr_r;
  logic [13:0]                   byte_addr_nxt;
  logic [tlnu_pkg::PairIdxW-1:0] pair_r;
  logic [tlnu_pkg::PairIdxW-1:0] pair_nxt;
  logic [7:0]                    store_r [tlnu_pkg::StoreDepth];

  logic [3:0] mag;
  logic       sgn;
  logic       no_y;
  logic [4:0] xpos;
  logic       skip;
  logic [4:0] dev;
  logic       closing;
  logic       copy_board;

  assign mag  = byte_addr_r[7:4];
  assign sgn  = byte_addr_r[8];
  assign no_y = byte_addr_r[3];
  assign xpos = byte_addr_r[13:9];
  assign skip = (mag == 4'd0) && sgn;

  always_comb begin
    if (mag == 4'd0) begin
      dev = tlnu_pkg::DevInf;
    end else if (sgn) begin
      dev = tlnu_pkg::DevInf + {1'b0, mag};
    end else begin
      dev = tlnu_pkg::DevInf - {1'b0, mag};
    end
  end

  assign last_pair  = (pair_r == tlnu_pkg::PairIdxW'(tlnu_pkg::BytePairs - 1));
  assign closing    = accept && !skip && last_pair;
  assign copy_board = (board_id == 8'd0) && (xpos == 5'd0) && (dev == 5'd0);

  assign close_info.emit      = closing && !no_y && !copy_board;
  assign close_info.board     = board_id;
  assign close_info.strip_x   = xpos;
  assign close_info.deviation = dev;

  always_comb begin
    for (int k = 0; k < tlnu_pkg::StoreDepth; k++) begin
      resps[2*k]   = store_r[k][7:4];
      resps[2*k+1] = store_r[k][3:0];
    end
    resps[tlnu_pkg::NumStrips-2] = lut_byte[7:4];
    resps[tlnu_pkg::NumStrips-1] = lut_byte[3:0];
  end

  always_comb begin
    byte_addr_nxt = byte_addr_r;
    pair_nxt      = pair_r;
    if (accept) begin
      byte_addr_nxt = byte_addr_r + 14'd1;
      if (!skip) begin
        pair_nxt = pair_r + tlnu_pkg::PairIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_addr_r <= '0;
      pair_r      <= '0;
    end else begin
      byte_addr_r <= byte_addr_nxt;
      pair_r      <= pair_nxt;
    end
  end

  // group slots; the closing pair comes straight from the input
  always_ff @(posedge clk) begin
    if (accept && !skip && !last_pair) begin
      store_r[pair_r] <= lut_byte;
    end
  end

endmodule

// ===== hdl/tlnu_merge.sv =====
// Merges the lane flags into the six masks and holds the result request.
module tlnu_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  tlnu_pkg::close_t                                close_info,
  input  tlnu_pkg::lane_flags_t [tlnu_pkg::NumStrips-1:0] flags,
  input  logic                                            out_stall,
  output logic                                            out_valid,
  output logic [7:0]                                      out_board,
  output logic [4:0]                                      out_strip_x,
  output logic [4:0]                                      out_deviation,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_low_minus_mask,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_low_undef_mask,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_low_plus_mask,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_high_minus_mask,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_high_undef_mask,
  output logic [tlnu_pkg::NumStrips-1:0]                  out_high_plus_mask
);

  logic valid_r;
  logic valid_nxt;

  logic [7:0]                   board_r;
  logic [4:0]                   strip_x_r;
  logic [4:0]                   dev_r;
  logic [tlnu_pkg::NumStrips-1:0] lm_r, lu_r, lp_r, hm_r, hu_r, hp_r;
  logic [tlnu_pkg::NumStrips-1:0] lm, lu, lp, hm, hu, hp;

  always_comb begin
    for (int n = 0; n < tlnu_pkg::NumStrips; n++) begin
      lm[n] = flags[n].low_minus;
      lu[n] = flags[n].low_undef;
      lp[n] = flags[n].low_plus;
      hm[n] = flags[n].high_minus;
      hu[n] = flags[n].high_undef;
      hp[n] = flags[n].high_plus;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (close_info.emit) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (close_info.emit) begin
      board_r   <= close_info.board;
      strip_x_r <= close_info.strip_x;
      dev_r     <= close_info.deviation;
      lm_r      <= lm;
      lu_r      <= lu;
      lp_r      <= lp;
      hm_r      <= hm;
      hu_r      <= hu;
      hp_r      <= hp;
    end
  end

  assign out_valid           = valid_r;
  assign out_board           = board_r;
  assign out_strip_x         = strip_x_r;
  assign out_deviation       = dev_r;
  assign out_low_minus_mask  = lm_r;
  assign out_low_undef_mask  = lu_r;
  assign out_low_plus_mask   = lp_r;
  assign out_high_minus_mask = hm_r;
  assign out_high_undef_mask = hu_r;
  assign out_high_plus_mask  = hp_r;

endmodule

// ===== hdl/trigger_lut_nibble_unpacker.sv =====
// Top level of the trigger look-up table nibble unpacker.
//
// Input: one table byte per request on in_lut_byte (in_valid / in_stall),
// high nibble the even address, low nibble the odd one. Output: one request
// per finished strip group with a y trigger, copy board groups apart,
// carrying board, x position, offline deviation and six 16-bit pt masks
// (out_valid / out_stall). One byte per cycle unless stalled. Sixteen
// lanes classify the strip responses of a group in parallel and the merge
// stage registers the masks, so a result appears in the cycle after the
// eighth byte of its group. Configuration: board_id over the APB port at
// address 0, to be written only while the stream is idle (not enforced).
// Reset clears the address counter, the group fill and the output request.
// A pending result waits in the output register; the input stalls only
// while that result is held and the next byte could close another group.

module trigger_lut_nibble_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_lut_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_board,
  output logic [4:0]  out_strip_x,
  output logic [4:0]  out_deviation,
  output logic [15:0] out_low_minus_mask,
  output logic [15:0] out_low_undef_mask,
  output logic [15:0] out_low_plus_mask,
  output logic [15:0] out_high_minus_mask,
  output logic [15:0] out_high_undef_mask,
  output logic [15:0] out_high_plus_mask
);

  logic [7:0] board_id_r;
  logic       in_accept;
  logic       last_pair;

  tlnu_pkg::close_t                                close_info;
  tlnu_pkg::resp_t       [tlnu_pkg::NumStrips-1:0] resps;
  tlnu_pkg::lane_flags_t [tlnu_pkg::NumStrips-1:0] flags;

  assign pready = 1'b1;
  assign prdata = (paddr == tlnu_pkg::AddrBoardId) ? {24'd0, board_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_id_r <= '0;
    end else if (psel && penable && pwrite && (paddr == tlnu_pkg::AddrBoardId)) begin
      board_id_r <= pwdata[7:0];
    end
  end

  assign in_stall  = out_valid && out_stall && last_pair;
  assign in_accept = in_valid && !in_stall;

  tlnu_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .lut_byte   (in_lut_byte),
    .board_id   (board_id_r),
    .last_pair  (last_pair),
    .close_info (close_info),
    .resps      (resps)
  );

  for (genvar g = 0; g < tlnu_pkg::NumStrips; g++) begin : g_lane
    tlnu_lane u_lane (
      .resp  (resps[g]),
      .flags (flags[g])
    );
  end

  tlnu_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .close_info          (close_info),
    .flags               (flags),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_board           (out_board),
    .out_strip_x         (out_strip_x),
    .out_deviation       (out_deviation),
    .out_low_minus_mask  (out_low_minus_mask),
    .out_low_undef_mask  (out_low_undef_mask),
    .out_low_plus_mask   (out_low_plus_mask),
    .out_high_minus_mask (out_high_minus_mask),
    .out_high_undef_mask (out_high_undef_mask),
    .out_high_plus_mask  (out_high_plus_mask)
  );

endmodule

// ===== hdl/tlnu_checker.sv =====
// Port-level checks for the trigger table nibble unpacker, bound to the top.
module tlnu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_board,
  input logic [4:0]  out_strip_x,
  input logic [4:0]  out_deviation,
  input logic [15:0] out_low_minus_mask,
  input logic [15:0] out_high_plus_mask
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present after reset");

  a_request_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result request without an accepted byte");

  a_no_copy_board: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_board == 8'd0 && out_strip_x == 5'd0 && out_deviation == 5'd0))
    else $error("copy board group emitted");

  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_deviation != 5'd31)
    else $error("deviation out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_low_minus_mask)
      && $stable(out_high_plus_mask) && $stable(out_strip_x))
    else $error("stalled result changed");

endmodule

bind trigger_lut_nibble_unpacker tlnu_checker u_tlnu_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the trigger look-up table nibble unpacker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned TableBytes   = 16384;
  localparam int unsigned PhaseBytes   = 166;
  localparam int unsigned NumPhases    = 9;

  typedef struct packed {
    logic [7:0]  board;
    logic [4:0]  strip_x;
    logic [4:0]  deviation;
    logic [15:0] low_minus;
    logic [15:0] low_undef;
    logic [15:0] low_plus;
    logic [15:0] high_minus;
    logic [15:0] high_undef;
    logic [15:0] high_plus;
  } strip_group_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_lut_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_board;
  logic [4:0]  out_strip_x;
  logic [4:0]  out_deviation;
  logic [15:0] out_low_minus_mask;
  logic [15:0] out_low_undef_mask;
  logic [15:0] out_low_plus_mask;
  logic [15:0] out_high_minus_mask;
  logic [15:0] out_high_undef_mask;
  logic [15:0] out_high_plus_mask;

  trigger_lut_nibble_unpacker u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_lut_byte         (in_lut_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_board           (out_board),
    .out_strip_x         (out_strip_x),
    .out_deviation       (out_deviation),
    .out_low_minus_mask  (out_low_minus_mask),
    .out_low_undef_mask  (out_low_undef_mask),
    .out_low_plus_mask   (out_low_plus_mask),
    .out_high_minus_mask (out_high_minus_mask),
    .out_high_undef_mask (out_high_undef_mask),
    .out_high_plus_mask  (out_high_plus_mask)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // byte stream and expected groups
  logic [7:0]   lut_bytes[$];
  strip_group_t pending_groups[$];

  // unpacker state as predicted
  logic [7:0]       board_cfg = '0;
  logic [13:0]      byte_addr = '0;
  logic [3:0]       group_fill = '0;
  tlnu_pkg::resp_t  strip_resp[tlnu_pkg::NumStrips];

  int unsigned mismatches = 0;
  int unsigned groups_seen = 0;
  int unsigned bytes_taken = 0;
  int unsigned copy_drops = 0;
  int unsigned max_strip_x = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  function automatic void feed_nibble(input logic [14:0] addr,
                                      input tlnu_pkg::resp_t resp);
    logic [4:0]   xon;
    logic [3:0]   mag;
    logic [4:0]   dev;
    logic [1:0]   lpt;
    logic [1:0]   hpt;
    strip_group_t grp;
    xon = addr[9:5];
    mag = xon[3:0];
    if (mag == 4'd0 && xon[4]) return;  // no x trigger
    if (mag == 4'd0) dev = tlnu_pkg::DevInf;
    else if (xon[4]) dev = tlnu_pkg::DevInf + {1'b0, mag};
    else dev = tlnu_pkg::DevInf - {1'b0, mag};
    strip_resp[group_fill] = resp;
    group_fill = group_fill + 4'd1;
    if (group_fill != 4'd0) return;
    if (addr[4]) return;  // no y trigger
    if (board_cfg == 8'd0 && addr[14:10] == 5'd0 && dev == 5'd0) begin
      copy_drops++;
      return;
    end
    grp = '0;
    grp.board = board_cfg;
    grp.strip_x = addr[14:10];
    grp.deviation = dev;
    for (int n = 0; n < tlnu_pkg::NumStrips; n++) begin
      lpt = strip_resp[n][1:0];
      hpt = strip_resp[n][3:2];
      grp.low_minus[n]  = (lpt == tlnu_pkg::RespMinus);
      grp.low_undef[n]  = (lpt == tlnu_pkg::RespUndef);
      grp.low_plus[n]   = (lpt == tlnu_pkg::RespPlus);
      grp.high_minus[n] = (hpt == tlnu_pkg::RespMinus);
      grp.high_undef[n] = (hpt == tlnu_pkg::RespUndef);
      grp.high_plus[n]  = (hpt == tlnu_pkg::RespPlus);
    end
    pending_groups.push_back(grp);
  endfunction

  function automatic void unpack_byte(input logic [7:0] lut_byte);
    feed_nibble({byte_addr, 1'b0}, lut_byte[7:4]);
    feed_nibble({byte_addr, 1'b1}, lut_byte[3:0]);
    byte_addr = byte_addr + 14'd1;
    bytes_taken++;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in group %0d, %s: expected %h, got %h",
                 groups_seen, name, exp_v, act_v);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) unpack_byte(in_lut_byte);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (lut_bytes.size() != 0) begin
          in_lut_byte <= lut_bytes.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    strip_group_t exp_g;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_groups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: board %h x %0d dev %0d",
                     out_board, out_strip_x, out_deviation);
        end else begin
          exp_g = pending_groups.pop_front();
          check_field("board", 16'(exp_g.board), 16'(out_board));
          check_field("strip_x", 16'(exp_g.strip_x), 16'(out_strip_x));
          check_field("deviation", 16'(exp_g.deviation), 16'(out_deviation));
          check_field("low_minus", exp_g.low_minus, out_low_minus_mask);
          check_field("low_undef", exp_g.low_undef, out_low_undef_mask);
          check_field("low_plus", exp_g.low_plus, out_low_plus_mask);
          check_field("high_minus", exp_g.high_minus, out_high_minus_mask);
          check_field("high_undef", exp_g.high_undef, out_high_undef_mask);
          check_field("high_plus", exp_g.high_plus, out_high_plus_mask);
          if (32'(exp_g.strip_x) > max_strip_x) max_strip_x = 32'(exp_g.strip_x);
        end
        groups_seen++;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 6);
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d groups outstanding",
               cycle_count, pending_groups.size());
      $display("trigger_lut_nibble_unpacker verification failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [0:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == tlnu_pkg::AddrBoardId) board_cfg = data[7:0];
  endtask

  task automatic apb_check_board();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= tlnu_pkg::AddrBoardId;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    check_field("board_id readback", {8'd0, board_cfg}, {8'd0, prdata[7:0]});
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (lut_bytes.size() != 0 || in_valid || pending_groups.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [7:0] random_byte(input int unsigned mode);
    logic [3:0] nib;
    nib = 4'($urandom_range(0, 15));
    case (mode)
      0: return {nib, nib};
      1: return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0]  board_plan[NumPhases];
    logic [7:0]  directed[16];
    int unsigned fill_mode;
    board_plan = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    for (int p = 1; p < NumPhases; p++) board_plan[p] = 8'($urandom_range(1, 254));
    board_plan[1] = 8'd1;
    board_plan[NumPhases - 2] = 8'd0;  // board 0 again away from the copy board addresses
    directed = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h55, 8'hAA, 8'hC3, 8'h3C,
                 8'h5A, 8'hA5, 8'h96, 8'h69, 8'h12, 8'h34, 8'h9F, 8'hE7};
    fill_mode = 2;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // board 0 from reset covers the copy board addresses of the first table
    apb_write(tlnu_pkg::AddrBoardId, 32'd0);
    apb_check_board();
    foreach (directed[i]) lut_bytes.push_back(directed[i]);
    for (int i = 0; i < 240; i++) lut_bytes.push_back(random_byte(2));
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      apb_write(tlnu_pkg::AddrBoardId, {24'($urandom_range(0, 16777215)), board_plan[p]});
      if (p == 3) apb_write(~tlnu_pkg::AddrBoardId, 32'($urandom_range(0, 255)));
      apb_check_board();
      for (int i = 0; i < PhaseBytes; i++) begin
        if (i % 8 == 0) fill_mode = $urandom_range(0, 3);
        lut_bytes.push_back(random_byte(fill_mode));
      end
      wait_idle();
    end

    $display("%0d table bytes (%0d full tables), %0d groups checked, %0d copy board drops",
             bytes_taken, bytes_taken / TableBytes, groups_seen, copy_drops);
    $display("board ids 0, 1, 255 and random ones; x positions 0..%0d reached", max_strip_x);
    if (pending_groups.size() != 0) mismatches += pending_groups.size();
    if (mismatches == 0) begin
      $display("trigger_lut_nibble_unpacker verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("trigger_lut_nibble_unpacker verification failed");
    end
    $finish;
  end

endmodule
